@@ sv/sbc_pkg.sv @@
// shared types, constants and register codes for the sensor board conditioner
`default_nettype none
package sbc_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int AXES      = 6;
    localparam int BUTTONS   = 3;
    localparam int RAW_W     = 16;
    localparam int FILT_W    = 24;
    localparam int SUPPLY_W  = 10;
    localparam int VOLT_FRAC = 8;
    localparam int VOLT_W    = SUPPLY_W + VOLT_FRAC;
    localparam int GAIN_W    = 9;
    localparam int GAIN_SHIFT = 8;
    localparam int PERIOD_W  = 16;
    localparam int AGE_W     = 16;
    localparam int EVENT_W   = 2;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 176;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_SHIFT);

    // x and y of both sensors are mirrored, z is kept
    localparam logic [AXES-1:0] AXIS_NEGATE = 6'b011011;

    localparam logic [GAIN_W-1:0]   IMU_GAIN_RST    = 9'd102;
    localparam logic [GAIN_W-1:0]   VOLT_GAIN_RST   = 9'd102;
    localparam logic [PERIOD_W-1:0] LONG_PRESS_RST  = 16'd250;
    localparam logic [PERIOD_W-1:0] REPORT_INTV_RST = 16'd125;
    localparam logic [SUPPLY_W-1:0] LOW_VOLT_RST    = 10'd110;
    localparam logic [AGE_W-1:0]    STALE_AGE_RST   = 16'd100;

    typedef logic signed [RAW_W-1:0]  raw_sample_t;
    typedef logic signed [FILT_W-1:0] filt_t;
    typedef logic [VOLT_W-1:0]        volt_t;

    typedef enum logic [2:0] {
        REG_IMU_GAIN    = 3'd0,
        REG_VOLT_GAIN   = 3'd1,
        REG_LONG_PRESS  = 3'd2,
        REG_REPORT_INTV = 3'd3,
        REG_LOW_VOLT    = 3'd4,
        REG_STALE_AGE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VS_NONE = 2'd0,
        VS_INFO = 2'd1,
        VS_WARN = 2'd2
    } volt_status_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } btn_event_t;

    typedef struct packed {
        volt_status_t status;
        volt_t        reported;
    } volt_report_t;

endpackage
`default_nettype wire

@@ sv/sbc_axis_lane.sv @@
// one imu axis: optional mirror, fixed-point scaling and exponential filter
`default_nettype none
module sbc_axis_lane (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      negate,
    input  wire sbc_pkg::raw_sample_t      raw,
    input  wire logic [sbc_pkg::GAIN_W-1:0] gain,
    output sbc_pkg::filt_t                 filt
);
    import sbc_pkg::*;

    localparam int X_W     = RAW_W + 1;
    localparam int CLAMP_W = (X_W + FRAC_BITS > FILT_W) ? X_W + FRAC_BITS : FILT_W + 1;
    localparam int DIFF_W  = FILT_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 2;

    localparam logic signed [CLAMP_W-1:0] SCALED_MAX = CLAMP_W'((1 << (FILT_W - 1)) - 1);
    localparam logic signed [CLAMP_W-1:0] SCALED_MIN = -CLAMP_W'(1 << (FILT_W - 1));
    localparam logic signed [PROD_W-1:0]  ACC_MAX    = PROD_W'((1 << (FILT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0]  ACC_MIN    = -PROD_W'(1 << (FILT_W - 1));
    localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1 << (GAIN_SHIFT - 1));

    filt_t                     filt_reg;
    filt_t                     filt_next;
    logic signed [X_W-1:0]     x_ext;
    logic signed [X_W-1:0]     x_sel;
    logic signed [CLAMP_W-1:0] x_scaled;
    filt_t                     x_clamped;
    logic signed [DIFF_W-1:0]  delta;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  acc;
    logic signed [PROD_W-1:0]  quot;

    always_comb begin
        x_ext    = X_W'(raw);
        x_sel    = negate ? -x_ext : x_ext;
        x_scaled = CLAMP_W'(x_sel) <<< FRAC_BITS;
        if (x_scaled > SCALED_MAX) begin
            x_clamped = FILT_W'(SCALED_MAX);
        end else if (x_scaled < SCALED_MIN) begin
            x_clamped = FILT_W'(SCALED_MIN);
        end else begin
            x_clamped = FILT_W'(x_scaled);
        end
        // g*x + (unity-g)*old folded into old*unity + g*(x - old)
        delta = DIFF_W'(x_clamped) - DIFF_W'(filt_reg);
        prod  = $signed({1'b0, gain}) * PROD_W'(delta);
        acc   = (PROD_W'(filt_reg) <<< GAIN_SHIFT) + prod + ROUND_HALF;
        quot  = acc >>> GAIN_SHIFT;
        if (quot > ACC_MAX) begin
            filt_next = FILT_W'(ACC_MAX);
        end else if (quot < ACC_MIN) begin
            filt_next = FILT_W'(ACC_MIN);
        end else begin
            filt_next = FILT_W'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (en) begin
            filt_reg <= filt_next;
        end
    end

    assign filt = filt_next;

endmodule
`default_nettype wire

@@ sv/sbc_button.sv @@
// one button: short press on early release, long press once the hold count passes the limit
`default_nettype none
module sbc_button (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         pushed,
    input  wire logic [sbc_pkg::PERIOD_W-1:0] long_limit,
    output sbc_pkg::btn_event_t               event_code
);
    import sbc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    logic                   held_reg;
    logic                   held_next;
    logic                   long_sent_reg;
    logic                   long_sent_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    btn_event_t             ev;

    always_comb begin
        held_next      = held_reg;
        long_sent_next = long_sent_reg;
        count_next     = count_reg;
        ev             = EV_NONE;
        if (pushed == held_reg) begin
            if (pushed) begin
                if (count_reg != '1) begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
                if (!long_sent_reg && (CMP_W'(count_next) > CMP_W'(long_limit))) begin
                    ev             = EV_LONG;
                    long_sent_next = 1'b1;
                end
            end
        end else begin
            held_next = pushed;
            if (pushed) begin
                count_next     = '0;
                long_sent_next = 1'b0;
            end else if (CMP_W'(count_reg) < CMP_W'(long_limit)) begin
                ev = EV_SHORT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= 1'b0;
            long_sent_reg <= 1'b0;
            count_reg     <= '0;
        end else if (en) begin
            held_reg      <= held_next;
            long_sent_reg <= long_sent_next;
            count_reg     <= count_next;
        end
    end

    assign event_code = ev;

endmodule
`default_nettype wire

@@ sv/sbc_volt.sv @@
// supply smoothing and rate-limited voltage status reporting
`default_nettype none
module sbc_volt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [sbc_pkg::SUPPLY_W-1:0] supply,
    input  wire logic [sbc_pkg::GAIN_W-1:0]   gain,
    input  wire logic [sbc_pkg::PERIOD_W-1:0] interval,
    input  wire logic [sbc_pkg::SUPPLY_W-1:0] threshold,
    output sbc_pkg::volt_report_t             report
);
    import sbc_pkg::*;

    localparam int DIFF_W = VOLT_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (GAIN_SHIFT - 1));
    localparam volt_t REPORT_STEP = VOLT_W'(1 << VOLT_FRAC);

    volt_t                    smooth_reg;
    volt_t                    smooth_next;
    volt_t                    last_reg;
    logic [PERIOD_W-1:0]      age_reg;
    logic [PERIOD_W-1:0]      age_inc;
    volt_t                    sample;
    logic signed [DIFF_W-1:0] delta;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;
    volt_t                    moved;
    logic                     fire;

    always_comb begin
        sample = {supply, VOLT_FRAC'(0)};
        delta  = $signed({1'b0, sample}) - $signed({1'b0, smooth_reg});
        prod   = $signed({1'b0, gain}) * PROD_W'(delta);
        step   = (prod + ROUND_HALF) >>> GAIN_SHIFT;
        sum    = SUM_W'($signed({1'b0, smooth_reg})) + SUM_W'(step);
        // a reading is loaded directly whenever the filter sits at zero
        if (smooth_reg == '0) begin
            smooth_next = sample;
        end else begin
            smooth_next = sum[VOLT_W-1:0];
        end
        age_inc = (age_reg == '1) ? age_reg : age_reg + PERIOD_W'(1);
        moved   = (smooth_next > last_reg) ? smooth_next - last_reg : last_reg - smooth_next;
        fire    = (moved >= REPORT_STEP) && (age_inc >= interval);
        report.status   = VS_NONE;
        report.reported = '0;
        if (fire) begin
            report.status   = (smooth_next < {threshold, VOLT_FRAC'(0)}) ? VS_WARN : VS_INFO;
            report.reported = smooth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            last_reg   <= '0;
            age_reg    <= '0;
        end else if (en) begin
            smooth_reg <= smooth_next;
            age_reg    <= fire ? '0 : age_inc;
            if (fire) begin
                last_reg <= smooth_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/sensor_board_conditioner.sv @@
// an input transaction is held in the input register and its result in the result register,
// which drives the m_axis side; throughput: one item per cycle unless m_axis_tready stalls;
// the two registers decouple both sides, all filter, button and voltage work sits between them
// reset: synchronous active-low aresetn clears all filter and button state and
// loads the default configuration; no clearing pass is needed
`default_nettype none
module sensor_board_conditioner (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z, supply_raw, button_bits, sample_age_ms
    input  wire logic [sbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // gyro_x..acc_z filt, button_events, volt_status, volt_reported, power_request
    output logic [sbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import sbc_pkg::*;

    localparam int SUPPLY_LSB = AXES * RAW_W;
    localparam int BTN_LSB    = SUPPLY_LSB + SUPPLY_W;
    localparam int AGE_LSB    = BTN_LSB + BUTTONS;
    localparam int OUT_USED_W = AXES * FILT_W + BUTTONS * EVENT_W + 2 + VOLT_W + 1;

    // configuration
    logic [GAIN_W-1:0]   imu_gain_reg;
    logic [GAIN_W-1:0]   volt_gain_reg;
    logic [PERIOD_W-1:0] long_press_reg;
    logic [PERIOD_W-1:0] report_intv_reg;
    logic [SUPPLY_W-1:0] low_volt_reg;
    logic [AGE_W-1:0]    stale_age_reg;
    logic                cfg_wr;
    cfg_idx_t            cfg_idx;

    // pipeline
    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  in_take;
    logic                  out_load;

    logic [GAIN_W-1:0]               imu_gain_eff;
    logic [GAIN_W-1:0]               volt_gain_eff;
    filt_t                           filt [AXES];
    btn_event_t                      btn_ev [BUTTONS];
    logic [BUTTONS*EVENT_W-1:0]      events;
    volt_report_t                    vrep;
    logic [BUTTONS-1:0]              buttons;
    logic [AGE_W-1:0]                sample_age;
    logic                            power_req;
    logic [OUT_USED_W-1:0]           result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imu_gain_reg    <= IMU_GAIN_RST;
            volt_gain_reg   <= VOLT_GAIN_RST;
            long_press_reg  <= LONG_PRESS_RST;
            report_intv_reg <= REPORT_INTV_RST;
            low_volt_reg    <= LOW_VOLT_RST;
            stale_age_reg   <= STALE_AGE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IMU_GAIN:    imu_gain_reg    <= pwdata[GAIN_W-1:0];
                REG_VOLT_GAIN:   volt_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_LONG_PRESS:  long_press_reg  <= pwdata[PERIOD_W-1:0];
                REG_REPORT_INTV: report_intv_reg <= pwdata[PERIOD_W-1:0];
                REG_LOW_VOLT:    low_volt_reg    <= pwdata[SUPPLY_W-1:0];
                REG_STALE_AGE:   stale_age_reg   <= pwdata[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMU_GAIN:    prdata = CFG_DATA_W'(imu_gain_reg);
            REG_VOLT_GAIN:   prdata = CFG_DATA_W'(volt_gain_reg);
            REG_LONG_PRESS:  prdata = CFG_DATA_W'(long_press_reg);
            REG_REPORT_INTV: prdata = CFG_DATA_W'(report_intv_reg);
            REG_LOW_VOLT:    prdata = CFG_DATA_W'(low_volt_reg);
            REG_STALE_AGE:   prdata = CFG_DATA_W'(stale_age_reg);
            default:         prdata = '0;
        endcase
    end

    // gains above unity act as unity
    assign imu_gain_eff  = (imu_gain_reg > GAIN_UNITY) ? GAIN_UNITY : imu_gain_reg;
    assign volt_gain_eff = (volt_gain_reg > GAIN_UNITY) ? GAIN_UNITY : volt_gain_reg;

    // handshake: the input register can take a new item when empty or when its item moves to the result register
    assign out_load      = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_vld_next  = in_take ? 1'b1 : (out_load ? 1'b0 : in_vld_reg);
        out_vld_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_axis_tdata;
        end
        if (out_load) begin
            out_data_reg <= OUT_DATA_W'(result);
        end
    end

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        sbc_axis_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (out_load),
            .negate  (AXIS_NEGATE[i]),
            .raw     (raw_sample_t'(in_data_reg[i*RAW_W +: RAW_W])),
            .gain    (imu_gain_eff),
            .filt    (filt[i])
        );
    end

    assign buttons = in_data_reg[BTN_LSB +: BUTTONS];

    for (genvar b = 0; b < BUTTONS; b++) begin : g_button
        sbc_button u_button (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (out_load),
            .pushed     (buttons[b]),
            .long_limit (long_press_reg),
            .event_code (btn_ev[b])
        );
        assign events[b*EVENT_W +: EVENT_W] = btn_ev[b];
    end

    sbc_volt u_volt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (out_load),
        .supply    (in_data_reg[SUPPLY_LSB +: SUPPLY_W]),
        .gain      (volt_gain_eff),
        .interval  (report_intv_reg),
        .threshold (low_volt_reg),
        .report    (vrep)
    );

    assign sample_age = in_data_reg[AGE_LSB +: AGE_W];
    assign power_req  = sample_age > stale_age_reg;

    assign result = {power_req, vrep.reported, vrep.status, events,
                     filt[5], filt[4], filt[3], filt[2], filt[1], filt[0]};

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the sensor board conditioner: stream stimulus, apb setup, scoreboard
module testbench;
    import sbc_pkg::*;

    localparam int  CLK_HALF   = 4;
    localparam int  RST_CYCLES = 11;
    localparam int  LONG_HOLD  = 300;
    localparam int  DRAIN_WAIT = 10;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  RAND_PHASES = 8;
    localparam int  PHASE_ITEMS = 56;
    localparam int  PRINT_CAP  = 30;

    // one control period, last field in the lowest bits
    typedef struct packed {
        logic [AGE_W-1:0]         age;
        logic [BUTTONS-1:0]       buttons;
        logic [SUPPLY_W-1:0]      supply;
        logic [AXES-1:0][RAW_W-1:0] axis;
    } sample_t;

    typedef struct packed {
        logic                      power;
        logic [VOLT_W-1:0]         reported;
        volt_status_t              status;
        logic [BUTTONS*EVENT_W-1:0] events;
        logic [AXES-1:0][FILT_W-1:0] axis;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    sensor_board_conditioner dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // register mirror
    int unsigned cfg_imu_gain  = IMU_GAIN_RST;
    int unsigned cfg_volt_gain = VOLT_GAIN_RST;
    int unsigned cfg_long      = LONG_PRESS_RST;
    int unsigned cfg_interval  = REPORT_INTV_RST;
    int unsigned cfg_low_volt  = LOW_VOLT_RST;
    int unsigned cfg_stale     = STALE_AGE_RST;

    // predicted block state
    longint      filt_state [AXES];
    int unsigned volt_smooth;
    int unsigned volt_last;
    int unsigned report_age;
    logic        btn_held [BUTTONS];
    logic        btn_long_sent [BUTTONS];
    int unsigned press_count [BUTTONS];

    sample_t pending_samples [$];
    result_t predicted_outputs [$];
    sample_t offered;

    int gap_left = 0;
    int burst_left = 0;
    int gap_max = 4;
    int burst_max = 8;
    int stall_pct = 20;
    int hold_request = 0;
    int hold_served = 0;
    int hold_left = 0;

    int errors = 0;
    int cycles = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_short = 0;
    int n_long = 0;
    int n_reports = 0;
    int n_settings = 1;

    // random stimulus shaping
    logic btn_level [BUTTONS];
    int   btn_span = 4;
    int   supply_level = 500;

    initial begin
        for (int a = 0; a < AXES; a++) filt_state[a] = 0;
        for (int b = 0; b < BUTTONS; b++) begin
            btn_held[b] = 1'b0;
            btn_long_sent[b] = 1'b0;
            press_count[b] = 0;
            btn_level[b] = 1'b0;
        end
        volt_smooth = 0;
        volt_last = 0;
        report_age = 0;
    end

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic result_t condition_sample(sample_t smp);
        result_t     r;
        longint      g;
        longint      x;
        longint      acc;
        int unsigned vg;
        int unsigned s;
        int unsigned diff;
        logic        pushed;
        logic [EVENT_W-1:0] ev;
        r = '0;
        g = (cfg_imu_gain > 256) ? 256 : cfg_imu_gain;
        vg = (cfg_volt_gain > 256) ? 256 : cfg_volt_gain;
        for (int a = 0; a < AXES; a++) begin
            x = longint'(signed'(smp.axis[a]));
            if (AXIS_NEGATE[a]) x = -x;
            x = sat24(x * (64'sd1 <<< FRAC_BITS));
            acc = g * x + (256 - g) * filt_state[a] + 128;
            filt_state[a] = sat24(acc >>> 8);
            r.axis[a] = filt_state[a][FILT_W-1:0];
        end
        for (int b = 0; b < BUTTONS; b++) begin
            pushed = smp.buttons[b];
            ev = EV_NONE;
            if (pushed == btn_held[b]) begin
                if (pushed) begin
                    if (press_count[b] < (1 << COUNT_WIDTH) - 1) press_count[b]++;
                    if (!btn_long_sent[b] && press_count[b] > cfg_long) begin
                        ev = EV_LONG;
                        btn_long_sent[b] = 1'b1;
                        n_long++;
                    end
                end
            end else begin
                btn_held[b] = pushed;
                if (pushed) begin
                    press_count[b] = 0;
                    btn_long_sent[b] = 1'b0;
                end else if (press_count[b] < cfg_long) begin
                    ev = EV_SHORT;
                    n_short++;
                end
            end
            r.events[EVENT_W*b +: EVENT_W] = ev;
        end
        s = int'(smp.supply) << VOLT_FRAC;
        // the smoother is seeded whenever it sits at zero
        if (volt_smooth != 0)
            volt_smooth = ((vg * s + (256 - vg) * volt_smooth + 128) >> 8) & 32'h3FFFF;
        else
            volt_smooth = s;
        if (report_age < 65535) report_age++;
        diff = (volt_smooth > volt_last) ? volt_smooth - volt_last : volt_last - volt_smooth;
        r.status = VS_NONE;
        if (diff >= (1 << VOLT_FRAC) && report_age >= cfg_interval) begin
            volt_last = volt_smooth;
            report_age = 0;
            r.status = (volt_smooth < (cfg_low_volt << VOLT_FRAC)) ? VS_WARN : VS_INFO;
            r.reported = volt_smooth[VOLT_W-1:0];
            n_reports++;
        end
        r.power = (int'(smp.age) > cfg_stale);
        return r;
    endfunction

    function automatic sample_t mk_sample(logic [RAW_W-1:0] axv, int sup, logic [2:0] btn,
                                          int age);
        sample_t smp;
        for (int a = 0; a < AXES; a++) smp.axis[a] = axv;
        smp.supply = sup[SUPPLY_W-1:0];
        smp.buttons = btn;
        smp.age = age[AGE_W-1:0];
        return smp;
    endfunction

    function automatic void queue_sample(sample_t smp);
        pending_samples.insert(pending_samples.size(), smp);
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        int      a_age;
        for (int a = 0; a < AXES; a++) begin
            case ($urandom_range(0, 9))
                0: smp.axis[a] = 16'h8000;
                1: smp.axis[a] = 16'h7FFF;
                2: smp.axis[a] = 16'h0000;
                3: smp.axis[a] = 16'($urandom_range(0, 15)) - 16'd8;
                default: smp.axis[a] = 16'($urandom());
            endcase
        end
        // held runs around the long-press limit, with some noise
        if ($urandom_range(0, 15) == 0) begin
            for (int b = 0; b < BUTTONS; b++) btn_level[b] = 1'($urandom());
        end else begin
            for (int b = 0; b < BUTTONS; b++)
                if ($urandom_range(0, btn_span) == 0) btn_level[b] = ~btn_level[b];
        end
        for (int b = 0; b < BUTTONS; b++) smp.buttons[b] = btn_level[b];
        case ($urandom_range(0, 29))
            0: supply_level = 0;
            1: supply_level = 1023;
            2, 3: supply_level = $urandom_range(0, 1023);
            default: begin
                supply_level = supply_level + $urandom_range(0, 12) - 6;
                if (supply_level < 0) supply_level = 0;
                if (supply_level > 1023) supply_level = 1023;
            end
        endcase
        smp.supply = supply_level[SUPPLY_W-1:0];
        case ($urandom_range(0, 9))
            0: a_age = 0;
            1: a_age = 65535;
            2: a_age = $urandom_range(0, 65535);
            default: begin
                a_age = int'(cfg_stale) + $urandom_range(0, 6) - 3;
                if (a_age < 0) a_age = 0;
                if (a_age > 65535) a_age = 65535;
            end
        endcase
        smp.age = a_age[AGE_W-1:0];
        return smp;
    endfunction

    function automatic int unsigned pick_gain(int slot);
        case (slot)
            0: return 0;
            1: return 256;
            2: return 511;
            3: return 1;
            default: begin
                if ($urandom_range(0, 3) == 0) return $urandom_range(257, 511);
                return $urandom_range(0, 256);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint expv, longint gotv);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     n_checked, what, expv, gotv);
    endtask

    task automatic apb_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMU_GAIN:    cfg_imu_gain  = value & 32'h1FF;
            REG_VOLT_GAIN:   cfg_volt_gain = value & 32'h1FF;
            REG_LONG_PRESS:  cfg_long      = value & 32'hFFFF;
            REG_REPORT_INTV: cfg_interval  = value & 32'hFFFF;
            REG_LOW_VOLT:    cfg_low_volt  = value & 32'h3FF;
            REG_STALE_AGE:   cfg_stale     = value & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // sender: bursts and gaps, valid held until the transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_outputs.insert(predicted_outputs.size(), condition_sample(offered));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    offered = pending_samples.pop_front();
                    s_axis_tdata <= IN_DATA_W'(offered);
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, burst_max);
                        gap_left = $urandom_range(0, gap_max);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result check against the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (predicted_outputs.size() == 0) begin
                report_mismatch("unexpected transaction", 0, longint'(m_axis_tdata[63:0]));
            end else begin
                want = predicted_outputs.pop_front();
                for (int a = 0; a < AXES; a++)
                    if (got.axis[a] !== want.axis[a])
                        report_mismatch($sformatf("axis %0d", a), want.axis[a], got.axis[a]);
                if (got.events !== want.events)
                    report_mismatch("button_events", want.events, got.events);
                if (got.status !== want.status)
                    report_mismatch("volt_status", want.status, got.status);
                if (got.reported !== want.reported)
                    report_mismatch("volt_reported", want.reported, got.reported);
                if (got.power !== want.power)
                    report_mismatch("power_request", want.power, got.power);
            end
            n_checked++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, predicted_outputs.size());
            $display("sensor_board_conditioner regression: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] v;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration: sample extremes and the stale boundary
        queue_sample(mk_sample(16'h8000, 0, 3'b000, 0));
        queue_sample(mk_sample(16'h7FFF, 1023, 3'b000, 65535));
        queue_sample(mk_sample(16'h0000, 1023, 3'b000, 100));
        queue_sample(mk_sample(16'h0001, 1023, 3'b000, 101));
        wait_idle();

        apb_write(REG_IMU_GAIN, 256);
        apb_write(REG_VOLT_GAIN, 256);
        apb_write(REG_LONG_PRESS, 2);
        apb_write(REG_REPORT_INTV, 1);
        apb_write(REG_LOW_VOLT, 500);
        apb_write(REG_STALE_AGE, 0);
        n_settings++;
        @(negedge aclk);
        queue_sample(mk_sample(16'h8000, 100, 3'b111, 0));
        queue_sample(mk_sample(16'h7FFF, 100, 3'b111, 1));
        queue_sample(mk_sample(16'hFFFF, 600, 3'b111, 2));
        queue_sample(mk_sample(16'h0000, 600, 3'b111, 3));  // long press
        queue_sample(mk_sample(16'h8000, 600, 3'b000, 0));
        queue_sample(mk_sample(16'h7FFF, 601, 3'b111, 0));  // move of exactly one report step
        queue_sample(mk_sample(16'h0000, 601, 3'b000, 0));  // short press
        queue_sample(mk_sample(16'h0000, 0, 3'b111, 0));
        queue_sample(mk_sample(16'h0000, 0, 3'b111, 0));    // smoother reseeds
        queue_sample(mk_sample(16'h0000, 500, 3'b111, 0));  // at low threshold
        queue_sample(mk_sample(16'h0000, 499, 3'b000, 0));  // release at the limit
        queue_sample(mk_sample(16'h0000, 499, 3'b001, 0));
        queue_sample(mk_sample(16'h0000, 499, 3'b010, 0));
        queue_sample(mk_sample(16'h0000, 499, 3'b100, 0));
        wait_idle();

        // zero long limit, over-range gain, frozen voltage filter
        apb_write(REG_IMU_GAIN, 511);
        apb_write(REG_VOLT_GAIN, 0);
        apb_write(REG_LONG_PRESS, 0);
        apb_write(REG_REPORT_INTV, 65535);
        apb_write(REG_LOW_VOLT, 1023);
        apb_write(REG_STALE_AGE, 65535);
        n_settings++;
        @(negedge aclk);
        queue_sample(mk_sample(16'h8000, 300, 3'b111, 65535));
        queue_sample(mk_sample(16'h8000, 300, 3'b111, 0));
        queue_sample(mk_sample(16'h7FFF, 300, 3'b000, 0));
        queue_sample(mk_sample(16'h0000, 300, 3'b111, 0));
        queue_sample(mk_sample(16'h0000, 300, 3'b000, 0));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            supply_level = $urandom_range(0, 1023);
            apb_write(REG_IMU_GAIN, pick_gain(ph));
            apb_write(REG_VOLT_GAIN, pick_gain((ph + 5) % RAND_PHASES));
            if (ph == 4) v = 65535;
            else if (ph == 5) v = 1;
            else v = $urandom_range(0, 12);
            apb_write(REG_LONG_PRESS, v);
            if (ph == 6) v = 65535;
            else if (ph == 7) v = 0;
            else v = $urandom_range(0, 6);
            apb_write(REG_REPORT_INTV, v);
            if (ph == 2) v = 0;
            else if (ph == 3) v = 1023;
            else if (ph == 7) v = $urandom();  // upper bits must be dropped
            else v = $urandom_range(0, 1023);
            apb_write(REG_LOW_VOLT, v);
            if (ph == 4) v = 0;
            else if (ph == 5) v = 65535;
            else if (ph == 7) v = $urandom();
            else v = $urandom_range(0, 2000);
            apb_write(REG_STALE_AGE, v);
            n_settings++;
            btn_span = (cfg_long < 40) ? int'(cfg_long) + 2 : 6;
            burst_max = $urandom_range(0, 20);
            gap_max = (ph == 2) ? 0 : $urandom_range(0, 8);
            case ($urandom_range(0, 4))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                3: stall_pct = 60;
                default: stall_pct = 75;
            endcase
            if (ph == 3) begin
                // back-pressure until the block stops taking input
                gap_max = 0;
                stall_pct = 0;
                hold_request++;
            end
            @(negedge aclk);
            for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(random_sample());
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("%0d periods over %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("button events: %0d short, %0d long; voltage reports: %0d",
                 n_short, n_long, n_reports);
        if (errors == 0) begin
            $display("sensor_board_conditioner regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("sensor_board_conditioner regression: fail");
        end
        $finish;
    end

endmodule
